@@ src/sgss_pkg.sv @@
package sgss_pkg;

  // gear numbering: 0 is neutral, lever order 1-N-2-3-...
  localparam logic [2:0] TOP_GEAR  = 3'd6;
  localparam logic [2:0] GEAR_N    = 3'd0;
  localparam logic [2:0] GEAR_1    = 3'd1;
  localparam logic [2:0] GEAR_2    = 3'd2;
  localparam logic [7:0] ANGLE_MAX = 8'd180;

  // last shift direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // servo command codes
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_DRIVE  = 2'd1;
  localparam logic [1:0] CMD_DETACH = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_UP_ANGLE     = 3'd0;
  localparam logic [2:0] CFG_DOWN_ANGLE   = 3'd1;
  localparam logic [2:0] CFG_CENTER_ANGLE = 3'd2;
  localparam logic [2:0] CFG_S2N_OFFSET   = 3'd3;
  localparam logic [2:0] CFG_BACKLASH     = 3'd4;
  localparam logic [2:0] CFG_COOLDOWN     = 3'd5;

  // configuration reset values
  localparam logic [7:0]  UP_ANGLE_RST     = 8'd120;
  localparam logic [7:0]  DOWN_ANGLE_RST   = 8'd60;
  localparam logic [7:0]  CENTER_ANGLE_RST = 8'd90;
  localparam logic [7:0]  S2N_OFFSET_RST   = 8'd13;
  localparam logic [5:0]  BACKLASH_RST     = 6'd4;
  localparam logic [15:0] COOLDOWN_RST     = 16'd1400;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  sensed_gear;
    logic        clutch_held;
    logic        up_request;
    logic        down_request;
  } item_t;

  typedef struct packed {
    logic [1:0] servo_command;
    logic [7:0] servo_angle;
    logic       goal_pending;
    logic [2:0] goal_shown;
  } result_t;

  typedef struct packed {
    logic [7:0]  up_angle;
    logic [7:0]  down_angle;
    logic [7:0]  center_angle;
    logic [7:0]  second_to_neutral_offset;
    logic [5:0]  backlash_degrees;
    logic [15:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  goal_gear;
    logic        goal_known;
    logic        shift_allowed;
    logic        servo_released;
    logic [31:0] last_shift_ms;
    logic [1:0]  last_direction;
  } state_t;

endpackage

@@ src/sgss_if.sv @@
interface sgss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [2:0]  sensed_gear;
  logic        clutch_held;
  logic        up_request;
  logic        down_request;

  modport source (
    output valid, now_ms, sensed_gear, clutch_held, up_request, down_request,
    input  ready
  );
  modport sink (
    input  valid, now_ms, sensed_gear, clutch_held, up_request, down_request,
    output ready
  );
endinterface

interface sgss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] servo_command;
  logic [7:0] servo_angle;
  logic       goal_pending;
  logic [2:0] goal_shown;

  modport source (
    output valid, servo_command, servo_angle, goal_pending, goal_shown,
    input  ready
  );
  modport sink (
    input  valid, servo_command, servo_angle, goal_pending, goal_shown,
    output ready
  );
endinterface

interface sgss_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ src/sequential_gear_shift_servo_control_top.sv @@
// sequential gear shift servo controller
//
// in_i carries one control tick per item: timestamp, sensed gear, clutch
// and the up/down buttons. out_o returns exactly one item per tick with the
// servo command, angle and goal gear for display. cfg_i writes the six
// setup registers (angles, backlash, cooldown) by index; it is always ready
// and is meant to be used only while no tick is in flight. writes to
// unused indexes are dropped.
//
// from acceptance to out_o valid a tick passes the tick register, then
// the step logic and the result register. one tick is accepted per cycle
// unless the receiver stalls; the controller state is updated as a tick
// moves into the result register, so the next tick already sees it.
//
// reset clears the goal (taken again from the first tick's sensed gear),
// allows shifting, sets the direction to none and loads the register
// defaults. if the receiver stalls, the result holds and the tick register
// fills; in_i.ready drops only when both stages are occupied.
module sequential_gear_shift_servo_control_top (
  input logic              clk_i,
  input logic              rst_ni,
  sgss_in_if.sink          in_i,
  sgss_out_if.source       out_o,
  sgss_cfg_if.sink         cfg_i
);

  sgss_pkg::cfg_t    cfg_q;
  sgss_pkg::state_t  state_q, state_d;
  sgss_pkg::item_t   item_q;
  sgss_pkg::result_t res_d, res_q;
  logic              item_valid_q, out_valid_q;
  logic              out_free, item_adv, in_take;

  // handshake: the result register frees the tick stage
  assign out_free = !out_valid_q || out_o.ready;
  assign item_adv = item_valid_q && out_free;
  assign in_take  = in_i.valid && in_i.ready;
  assign in_i.ready  = !item_valid_q || item_adv;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_angle                 <= sgss_pkg::UP_ANGLE_RST;
      cfg_q.down_angle               <= sgss_pkg::DOWN_ANGLE_RST;
      cfg_q.center_angle             <= sgss_pkg::CENTER_ANGLE_RST;
      cfg_q.second_to_neutral_offset <= sgss_pkg::S2N_OFFSET_RST;
      cfg_q.backlash_degrees         <= sgss_pkg::BACKLASH_RST;
      cfg_q.cooldown_ms              <= sgss_pkg::COOLDOWN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sgss_pkg::CFG_UP_ANGLE:     cfg_q.up_angle                 <= cfg_i.data[7:0];
        sgss_pkg::CFG_DOWN_ANGLE:   cfg_q.down_angle               <= cfg_i.data[7:0];
        sgss_pkg::CFG_CENTER_ANGLE: cfg_q.center_angle             <= cfg_i.data[7:0];
        sgss_pkg::CFG_S2N_OFFSET:   cfg_q.second_to_neutral_offset <= cfg_i.data[7:0];
        sgss_pkg::CFG_BACKLASH:     cfg_q.backlash_degrees         <= cfg_i.data[5:0];
        sgss_pkg::CFG_COOLDOWN:     cfg_q.cooldown_ms              <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // tick register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.now_ms       <= in_i.now_ms;
      item_q.sensed_gear  <= in_i.sensed_gear;
      item_q.clutch_held  <= in_i.clutch_held;
      item_q.up_request   <= in_i.up_request;
      item_q.down_request <= in_i.down_request;
    end
  end

  // per-tick decision logic
  sgss_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // result register payload
  always_ff @(posedge clk_i) begin
    if (item_adv) begin
      res_q <= res_d;
    end
  end

  // valid flags and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q           <= 1'b0;
      out_valid_q            <= 1'b0;
      state_q.goal_gear      <= sgss_pkg::GEAR_N;
      state_q.goal_known     <= 1'b0;
      state_q.shift_allowed  <= 1'b1;
      state_q.servo_released <= 1'b0;
      state_q.last_shift_ms  <= 32'd0;
      state_q.last_direction <= sgss_pkg::DIR_NONE;
    end else begin
      if (in_i.ready) begin
        item_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= item_valid_q;
      end
      if (item_adv) begin
        state_q <= state_d;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.servo_command = res_q.servo_command;
  assign out_o.servo_angle   = res_q.servo_angle;
  assign out_o.goal_pending  = res_q.goal_pending;
  assign out_o.goal_shown    = res_q.goal_shown;

  // goal, once taken from the sensor, is never forgotten
  a_goal_known_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q.goal_known) |-> state_q.goal_known)
    else $error("goal_known cleared after being set");

  // a detach always leaves the servo marked released
  a_detach_marks_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_adv && res_d.servo_command == sgss_pkg::CMD_DETACH) |=> state_q.servo_released)
    else $error("detach issued without marking servo released");

  // a pending goal always drives the servo
  a_pending_drives : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_adv && res_d.goal_pending) |=>
      (out_valid_q && res_q.servo_command == sgss_pkg::CMD_DRIVE))
    else $error("pending goal without a drive command");

  // angles stay inside the servo range
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.servo_angle <= sgss_pkg::ANGLE_MAX))
    else $error("servo angle above range");

  // an empty result register never blocks the input side
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule

@@ src/sgss_step.sv @@
module sgss_step (
  input  sgss_pkg::item_t   item_i,
  input  sgss_pkg::state_t  state_i,
  input  sgss_pkg::cfg_t    cfg_i,
  output sgss_pkg::state_t  state_o,
  output sgss_pkg::result_t result_o
);

  function automatic logic [7:0] clamp_pos(input logic [8:0] a);
    if (a > {1'b0, sgss_pkg::ANGLE_MAX}) begin
      return sgss_pkg::ANGLE_MAX;
    end
    return a[7:0];
  endfunction

  // a - b clamped to 0..180
  function automatic logic [7:0] clamp_diff(input logic [7:0] a, input logic [7:0] b);
    logic [9:0] d;
    d = {2'b00, a} - {2'b00, b};
    if (d[9]) begin
      return 8'd0;
    end
    return clamp_pos(d[8:0]);
  endfunction

  logic [2:0]  goal0, goal1;
  logic        up_ok, down_ok, shifted, allowed_mid;
  logic [31:0] last_ms1, elapsed;
  logic        expired;
  logic [1:0]  dir1;
  logic [7:0]  shift_angle, rest_angle;
  logic        released1, match;

  assign goal0 = state_i.goal_known ? state_i.goal_gear : item_i.sensed_gear;

  // up is tried first and blocks a down in the same tick
  assign up_ok = item_i.up_request && state_i.shift_allowed && item_i.clutch_held
                 && (goal0 < sgss_pkg::TOP_GEAR);
  assign allowed_mid = state_i.shift_allowed && !up_ok;
  assign down_ok = item_i.down_request && allowed_mid && item_i.clutch_held
                   && (goal0 != sgss_pkg::GEAR_N);

  always_comb begin
    goal1 = goal0;
    dir1  = state_i.last_direction;
    if (up_ok) begin
      goal1 = goal0 + 3'd1;
      dir1  = (goal1 == sgss_pkg::GEAR_1) ? sgss_pkg::DIR_DOWN : sgss_pkg::DIR_UP;
    end
    if (down_ok) begin
      goal1 = goal0 - 3'd1;
      dir1  = sgss_pkg::DIR_DOWN;
    end
  end

  assign shifted   = up_ok || down_ok;
  assign last_ms1  = shifted ? item_i.now_ms : state_i.last_shift_ms;
  assign released1 = shifted ? 1'b0 : state_i.servo_released;

  // wrapping elapsed time against a 16 bit cooldown
  assign elapsed = item_i.now_ms - last_ms1;
  assign expired = (elapsed[31:16] != 16'd0) || (elapsed[15:0] > cfg_i.cooldown_ms);

  assign match = (goal1 == item_i.sensed_gear);

  always_comb begin
    if (item_i.sensed_gear == sgss_pkg::GEAR_N && goal1 == sgss_pkg::GEAR_1) begin
      shift_angle = clamp_pos({1'b0, cfg_i.down_angle});
    end else if (item_i.sensed_gear == sgss_pkg::GEAR_1 && goal1 == sgss_pkg::GEAR_N) begin
      shift_angle = clamp_pos({1'b0, cfg_i.up_angle});
    end else if (item_i.sensed_gear == sgss_pkg::GEAR_2 && goal1 == sgss_pkg::GEAR_N) begin
      shift_angle = clamp_diff(cfg_i.down_angle, cfg_i.second_to_neutral_offset);
    end else if (goal1 > item_i.sensed_gear) begin
      shift_angle = clamp_pos({1'b0, cfg_i.up_angle});
    end else begin
      shift_angle = clamp_pos({1'b0, cfg_i.down_angle});
    end
  end

  always_comb begin
    case (dir1)
      sgss_pkg::DIR_UP:
        rest_angle = clamp_pos({1'b0, cfg_i.center_angle} + {3'b000, cfg_i.backlash_degrees});
      sgss_pkg::DIR_DOWN:
        rest_angle = clamp_diff(cfg_i.center_angle, {2'b00, cfg_i.backlash_degrees});
      default:
        rest_angle = clamp_pos({1'b0, cfg_i.center_angle});
    endcase
  end

  always_comb begin
    state_o.goal_gear      = goal1;
    state_o.goal_known     = 1'b1;
    state_o.shift_allowed  = (state_i.shift_allowed && !shifted) || expired;
    state_o.servo_released = released1;
    state_o.last_shift_ms  = last_ms1;
    state_o.last_direction = dir1;
    result_o.servo_command = sgss_pkg::CMD_HOLD;
    result_o.servo_angle   = 8'd0;
    result_o.goal_pending  = !match;
    result_o.goal_shown    = match ? 3'd0 : goal1;
    if (match) begin
      if (!released1) begin
        if (expired) begin
          result_o.servo_command = sgss_pkg::CMD_DETACH;
          state_o.servo_released = 1'b1;
        end else begin
          result_o.servo_command = sgss_pkg::CMD_DRIVE;
          result_o.servo_angle   = rest_angle;
        end
      end
    end else begin
      result_o.servo_command = sgss_pkg::CMD_DRIVE;
      result_o.servo_angle   = shift_angle;
      state_o.last_shift_ms  = item_i.now_ms;
      state_o.servo_released = 1'b0;
    end
  end

endmodule

@@ test/sequential_gear_shift_servo_control_top_tb.sv @@
`timescale 1ns / 100ps

module sequential_gear_shift_servo_control_top_tb;
  import sgss_pkg::*;

  // run limit in cycles, far above the slowest legal run
  localparam int MAX_CYCLES = 200000;
  // cycles to let pass once nothing is expected
  localparam int SETTLE_CYCLES = 4;
  // random ticks per configuration phase
  localparam int PHASE_TICKS = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sgss_in_if  tick_if ();
  sgss_out_if servo_if ();
  sgss_cfg_if cfg_if ();

  sequential_gear_shift_servo_control_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (servo_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // mirror of the controller: register settings and tick-to-tick state
  cfg_t        cfg_m;
  logic [2:0]  gear_goal;
  logic        goal_set;
  logic        shifting_ok;
  logic        servo_parked;
  logic [31:0] shift_stamp;
  logic [1:0]  shift_dir;

  // servo results still owed by the block, oldest first
  result_t servo_due[$];
  result_t want_res;
  int      fail_cnt;

  // sender pacing and the simulated gearbox that follows the goal
  int          burst_left;
  logic [31:0] tick_ms;
  logic [2:0]  gearbox_pos;

  // ---------------------------------------------------------------------------
  // servo result prediction
  // ---------------------------------------------------------------------------

  // servo angles are limited to 0..180 degrees
  function automatic logic [7:0] clamp_deg(input int a);
    if (a < 0) return 8'd0;
    if (a > int'(ANGLE_MAX)) return ANGLE_MAX;
    return a[7:0];
  endfunction

  // lever angle for a pending shift from the sensed gear to the goal
  function automatic logic [7:0] shift_angle(input logic [2:0] from_g, input logic [2:0] to_g);
    // neutral sits between first and second, so these moves are special
    if (from_g == GEAR_N && to_g == GEAR_1) return clamp_deg(int'(cfg_m.down_angle));
    if (from_g == GEAR_1 && to_g == GEAR_N) return clamp_deg(int'(cfg_m.up_angle));
    // second to neutral is a half push down
    if (from_g == GEAR_2 && to_g == GEAR_N)
      return clamp_deg(int'(cfg_m.down_angle) - int'(cfg_m.second_to_neutral_offset));
    if (to_g > from_g) return clamp_deg(int'(cfg_m.up_angle));
    return clamp_deg(int'(cfg_m.down_angle));
  endfunction

  function automatic void begin_shift(input logic [31:0] stamp, input logic [1:0] dir);
    shift_stamp  = stamp;
    servo_parked = 1'b0;
    shifting_ok  = 1'b0;
    shift_dir    = dir;
  endfunction

  // one control tick: updates the mirror and returns the servo result
  function automatic result_t compute_servo_result(input item_t t);
    result_t     r;
    logic [31:0] elapsed;
    int          a;
    r = '0;
    // the first tick after reset adopts the sensed gear as goal
    if (!goal_set) begin
      gear_goal = t.sensed_gear;
      goal_set  = 1'b1;
    end
    // up has priority; going up into first is a downward lever push
    if (t.up_request && shifting_ok && t.clutch_held && gear_goal < TOP_GEAR) begin
      gear_goal = gear_goal + 3'd1;
      begin_shift(t.now_ms, (gear_goal == GEAR_1) ? DIR_DOWN : DIR_UP);
    end
    if (t.down_request && shifting_ok && t.clutch_held && gear_goal > GEAR_N) begin
      gear_goal = gear_goal - 3'd1;
      begin_shift(t.now_ms, DIR_DOWN);
    end
    // elapsed time wraps at 32 bits
    elapsed = t.now_ms - shift_stamp;
    if (!shifting_ok && elapsed > 32'(cfg_m.cooldown_ms)) shifting_ok = 1'b1;
    if (gear_goal == t.sensed_gear) begin
      if (!servo_parked) begin
        if (elapsed > 32'(cfg_m.cooldown_ms)) begin
          r.servo_command = CMD_DETACH;
          servo_parked    = 1'b1;
        end else begin
          // rest angle leans toward the last shift direction
          a = int'(cfg_m.center_angle);
          if (shift_dir == DIR_UP) a = a + int'(cfg_m.backlash_degrees);
          else if (shift_dir == DIR_DOWN) a = a - int'(cfg_m.backlash_degrees);
          r.servo_command = CMD_DRIVE;
          r.servo_angle   = clamp_deg(a);
        end
      end
    end else begin
      // still shifting: keep pushing and restart the shift time
      r.servo_command = CMD_DRIVE;
      r.servo_angle   = shift_angle(t.sensed_gear, gear_goal);
      shift_stamp     = t.now_ms;
      servo_parked    = 1'b0;
    end
    r.goal_pending = (gear_goal != t.sensed_gear);
    r.goal_shown   = r.goal_pending ? gear_goal : GEAR_N;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // tick sender, register writer, hold-off
  // ---------------------------------------------------------------------------

  // called just after a falling edge; returns just after the one that follows acceptance
  task automatic send_tick(input logic [31:0] now, input logic [2:0] sensed,
                           input logic clutch, input logic up, input logic down);
    item_t t;
    int    gap;
    t.now_ms       = now;
    t.sensed_gear  = sensed;
    t.clutch_held  = clutch;
    t.up_request   = up;
    t.down_request = down;
    // bursts of random length, sometimes long, with random gaps between
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    tick_if.valid        <= 1'b1;
    tick_if.now_ms       <= t.now_ms;
    tick_if.sensed_gear  <= t.sensed_gear;
    tick_if.clutch_held  <= t.clutch_held;
    tick_if.up_request   <= t.up_request;
    tick_if.down_request <= t.down_request;
    do @(posedge clk_i); while (!tick_if.ready);
    servo_due.push_back(compute_servo_result(t));
    @(negedge clk_i);
  endtask

  // stop sending until every owed result is back, then let the pipe settle
  task automatic pause_until_drained();
    tick_if.valid <= 1'b0;
    while (servo_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    // the block keeps only the low bits of every register but the cooldown
    case (idx)
      CFG_UP_ANGLE:     cfg_m.up_angle                 = value[7:0];
      CFG_DOWN_ANGLE:   cfg_m.down_angle               = value[7:0];
      CFG_CENTER_ANGLE: cfg_m.center_angle             = value[7:0];
      CFG_S2N_OFFSET:   cfg_m.second_to_neutral_offset = value[7:0];
      CFG_BACKLASH:     cfg_m.backlash_degrees         = value[5:0];
      CFG_COOLDOWN:     cfg_m.cooldown_ms              = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // full register setup, only ever done with the block idle
  task automatic apply_setup(input logic [15:0] up_a, input logic [15:0] down_a,
                             input logic [15:0] center_a, input logic [15:0] offset_a,
                             input logic [15:0] backlash_a, input logic [15:0] cool_a);
    pause_until_drained();
    write_reg(CFG_UP_ANGLE, up_a);
    write_reg(CFG_DOWN_ANGLE, down_a);
    write_reg(CFG_CENTER_ANGLE, center_a);
    write_reg(CFG_S2N_OFFSET, offset_a);
    write_reg(CFG_BACKLASH, backlash_a);
    write_reg(CFG_COOLDOWN, cool_a);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // first tick takes the goal from a sensed gear above top, so up is refused;
  // cooldown boundary, detach, release and clutch gating at reset settings
  task automatic test_first_tick_and_cooldown();
    send_tick(32'd1000, 3'd7, 1'b1, 1'b1, 1'b0);  // goal 7, up refused, rest at center
    send_tick(32'd1010, 3'd7, 1'b1, 1'b1, 1'b1);  // up refused, down to 6
    send_tick(32'd1020, 3'd6, 1'b0, 1'b0, 1'b0);  // matched, rest minus backlash
    send_tick(32'd2410, 3'd6, 1'b1, 1'b1, 1'b1);  // elapsed equals cooldown
    send_tick(32'd2411, 3'd6, 1'b1, 1'b1, 1'b1);  // one past: detach
    send_tick(32'd2412, 3'd6, 1'b0, 1'b1, 1'b1);  // released, no clutch
    send_tick(32'd2413, 3'd6, 1'b1, 1'b1, 1'b1);  // up at top refused, down to 5
  endtask

  // walk the lever down through neutral and back, across the timestamp wrap:
  // 2->N half shift, N->1 push down, 1->N push up, and up winning over down
  task automatic test_lever_walk();
    logic up, down;
    tick_ms     = 32'hFFFF_E000;
    gearbox_pos = gear_goal;
    send_tick(tick_ms, gearbox_pos, 1'b0, 1'b0, 1'b0);
    tick_ms = tick_ms + 32'd1;
    for (int i = 0; i < 8; i++) begin
      up   = (i == 5 || i == 7);
      down = (i < 5 || i == 6 || i == 7);
      send_tick(tick_ms, gearbox_pos, 1'b1, up, down);
      // gearbox stays in second once so the next down asks for neutral from second
      if (i != 3) gearbox_pos = gear_goal;
      // settle past the cooldown so the next button is taken
      tick_ms = tick_ms + 32'd1501;
      send_tick(tick_ms, gearbox_pos, 1'b0, 1'b0, 1'b0);
      tick_ms = tick_ms + 32'd1;
    end
  endtask

  // random ticks under several register settings, extremes included; the
  // gearbox mostly follows the goal, with noise on the sensed gear and time
  task automatic test_random_drive();
    int pick;
    int cool;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: apply_setup(16'd120, 16'd60, 16'd90, 16'd13, 16'd4, 16'd40);
        1: apply_setup(16'd255, 16'd255, 16'd255, 16'd0, 16'd63, 16'd0);
        2: apply_setup(16'd0, 16'd0, 16'd0, 16'd255, 16'd45, 16'd65535);
        3: apply_setup(16'd180, 16'd180, 16'd180, 16'd180, 16'd45, 16'd1);
        default: apply_setup(16'($urandom()), 16'($urandom()), 16'($urandom()),
                             16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 3000)));
      endcase
      cool = int'(cfg_m.cooldown_ms);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) tick_ms = $urandom();
        else if (pick < 3)
          // land right on the cooldown boundary or one past it
          tick_ms = shift_stamp + 32'(cfg_m.cooldown_ms) + 32'($urandom_range(0, 1));
        else tick_ms = tick_ms + 32'($urandom_range(1, cool / 4 + 3));
        if (gearbox_pos != gear_goal && $urandom_range(0, 2) == 0) gearbox_pos = gear_goal;
        send_tick(tick_ms,
                  (pick >= 18) ? 3'($urandom_range(0, 7)) : gearbox_pos,
                  1'($urandom_range(0, 3) != 0),
                  1'($urandom_range(0, 2) == 0),
                  1'($urandom_range(0, 2) == 0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && servo_if.valid && servo_if.ready) begin
      if (servo_due.size() == 0) begin
        $error("servo result with no tick waiting");
        fail_cnt++;
      end else begin
        want_res = servo_due.pop_front();
        // unknown bits in a result never compare equal
        if ($isunknown({servo_if.servo_command, servo_if.servo_angle,
                        servo_if.goal_pending, servo_if.goal_shown})) begin
          $error("servo result has unknown bits");
          fail_cnt++;
        end else begin
          check_field("servo_command", want_res.servo_command, servo_if.servo_command);
          check_field("servo_angle", want_res.servo_angle, servo_if.servo_angle);
          check_field("goal_pending", want_res.goal_pending, servo_if.goal_pending);
          check_field("goal_shown", want_res.goal_shown, servo_if.goal_shown);
        end
      end
    end
  end

  // receiver stalls: modes held for a while, from always ready to long stalls
  initial begin
    int beat;
    int mode;
    int hold;
    beat = 0;
    mode = 0;
    hold = 0;
    servo_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(40, 200);
      end
      hold--;
      beat++;
      case (mode)
        0: servo_if.ready <= 1'b1;
        1: servo_if.ready <= (beat % 4) != 0;
        2: servo_if.ready <= 1'($urandom_range(0, 1));
        default: servo_if.ready <= (beat % 16) < 4;
      endcase
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sequential_gear_shift_servo_control_top verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    tick_if.valid        = 1'b0;
    tick_if.now_ms       = '0;
    tick_if.sensed_gear  = '0;
    tick_if.clutch_held  = 1'b0;
    tick_if.up_request   = 1'b0;
    tick_if.down_request = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    fail_cnt             = 0;
    burst_left           = 0;
    tick_ms              = '0;
    gearbox_pos          = GEAR_N;

    // mirror starts from the reset defaults
    cfg_m.up_angle                 = UP_ANGLE_RST;
    cfg_m.down_angle               = DOWN_ANGLE_RST;
    cfg_m.center_angle             = CENTER_ANGLE_RST;
    cfg_m.second_to_neutral_offset = S2N_OFFSET_RST;
    cfg_m.backlash_degrees         = BACKLASH_RST;
    cfg_m.cooldown_ms              = COOLDOWN_RST;
    gear_goal    = GEAR_N;
    goal_set     = 1'b0;
    shifting_ok  = 1'b1;
    servo_parked = 1'b0;
    shift_stamp  = '0;
    shift_dir    = DIR_NONE;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_first_tick_and_cooldown();
    test_lever_walk();
    test_random_drive();

    // everything sent: wait for the last results and let the pipe settle
    pause_until_drained();
    if (fail_cnt == 0) begin
      $display("sequential_gear_shift_servo_control_top verification clean");
    end else begin
      $display("sequential_gear_shift_servo_control_top verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/sgss_pkg.sv
src/sgss_if.sv
src/sgss_step.sv
src/sequential_gear_shift_servo_control_top.sv
test/sequential_gear_shift_servo_control_top_tb.sv
